>>> src/rfsd_pkg.sv
// ----------------------------------------------------------------------------
// rfsd_pkg: shared types and constants of the frame sync deframer
// Holds the frame markers, the frame length, the payload width and the
// structure that carries a finished frame from the tracker to the top level.
// ----------------------------------------------------------------------------
package rfsd_pkg;

  localparam int unsigned FrameLen    = 9;
  localparam int unsigned PayloadW    = 48;
  localparam int unsigned CountW      = 4;

  localparam logic [7:0] HdrA = 8'h5B;
  localparam logic [7:0] HdrB = 8'h5C;
  localparam logic [7:0] FtrA = 8'h2B;
  localparam logic [7:0] FtrB = 8'h2C;

  typedef struct packed {
    logic                hit;
    logic                frame_type;
    logic [PayloadW-1:0] payload;
  } frame_t;

endpackage

>>> src/rfsd_frame_fsm.sv
// ----------------------------------------------------------------------------
// rfsd_frame_fsm: frame synchronization tracker
// Hunts the doubled header, collects the payload bytes and checks the footer.
// Reports a finished frame combinationally in the cycle its footer is taken.
// ----------------------------------------------------------------------------
module rfsd_frame_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                beat_i,
  input  logic [7:0]          rx_byte_i,
  output rfsd_pkg::frame_t    frame_o
);

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhSecond  = 2'd1;
  localparam logic [1:0] PhCollect = 2'd2;

  logic [1:0]                      phase_q, phase_d;
  logic                            kind_q, kind_d;
  logic [rfsd_pkg::CountW-1:0]     count_q, count_d;
  logic [rfsd_pkg::PayloadW-1:0]   pay_q, pay_d;
  logic                            is_hdr, kind_in, last_byte, hit;
  logic [rfsd_pkg::CountW:0]       count_inc;
  logic [7:0]                      want;

  assign is_hdr    = (rx_byte_i == rfsd_pkg::HdrA) || (rx_byte_i == rfsd_pkg::HdrB);
  assign kind_in   = (rx_byte_i == rfsd_pkg::HdrB);
  assign count_inc = {1'b0, count_q} + (rfsd_pkg::CountW+1)'(1);
  assign last_byte = (count_inc >= (rfsd_pkg::CountW+1)'(rfsd_pkg::FrameLen));
  assign want      = kind_q ? rfsd_pkg::FtrB : rfsd_pkg::FtrA;

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    count_d = count_q;
    pay_d   = pay_q;
    hit     = 1'b0;
    if (beat_i) begin
      case (phase_q)
        PhSecond: begin
          if (is_hdr && (kind_in == kind_q)) begin
            count_d = rfsd_pkg::CountW'(2);
            pay_d   = '0;
            phase_d = PhCollect;
          end else if (is_hdr) begin
            kind_d = kind_in;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCollect: begin
          if (last_byte) begin
            phase_d = PhHunt;
            count_d = '0;
            hit     = (rx_byte_i == want);
          end else begin
            pay_d   = {pay_q[rfsd_pkg::PayloadW-9:0], rx_byte_i};
            count_d = count_inc[rfsd_pkg::CountW-1:0];
          end
        end
        default: begin
          // Hunting, and the unused phase code behaves the same way.
          phase_d = is_hdr ? PhSecond : PhHunt;
          if (is_hdr) begin
            kind_d = kind_in;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      kind_q  <= 1'b0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      count_q <= count_d;
    end
  end

  // The payload is cleared at every frame start before it is read.
  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign frame_o.hit        = hit;
  assign frame_o.frame_type = kind_q;
  assign frame_o.payload    = pay_q;

endmodule

>>> src/remote_frame_sync_deframer_unit.sv
// ----------------------------------------------------------------------------
// remote_frame_sync_deframer_unit: byte stream frame synchronizer
// Finds nine-byte frames with a doubled header, six payload bytes and a
// matching footer, and emits the frame type with the 48-bit payload.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_ready_o, rx_byte_i) takes one received
// byte per beat, in arrival order. The output channel (out_valid_o,
// out_ready_i, frame_type_o, payload_o) gives one beat for every frame whose
// footer matches its header; frames with a bad footer vanish silently.
// Each byte is handled in the cycle it is accepted by the tracker, so a new
// byte can be taken in every cycle while in_ready_o is high. A frame result
// is registered and appears in the cycle after its footer byte is accepted.
// When the receiver stalls, the result register holds its frame and
// in_ready_o stays low until that frame is taken, whatever the next byte is.
// in_ready_o only drops while a result is held and not being taken in the
// same cycle, so the throughput is one byte per cycle with no stall
// downstream.
// Reset puts the tracker back to hunting for a first header and empties the
// result register; no payload state needs clearing.
// ----------------------------------------------------------------------------
module remote_frame_sync_deframer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          frame_type_o,
  output logic [rfsd_pkg::PayloadW-1:0] payload_o
);

  rfsd_pkg::frame_t               frame;
  logic                           beat_in;
  logic                           out_valid_q, out_valid_d;
  logic                           type_q;
  logic [rfsd_pkg::PayloadW-1:0]  pay_q;

  // Input is taken whenever the result register is empty or being drained,
  // so a byte that completes a frame always finds room.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign beat_in    = in_valid_i && in_ready_o;

  rfsd_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat_in),
    .rx_byte_i (rx_byte_i),
    .frame_o   (frame)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (frame.hit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The result payload loads only when a good frame completes.
  always_ff @(posedge clk_i) begin
    if (frame.hit) begin
      type_q <= frame.frame_type;
      pay_q  <= frame.payload;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_type_o = type_q;
  assign payload_o    = pay_q;

  // An empty result register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

  // A new result only shows up after an input byte was accepted.
  a_result_from_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted byte");

  // A taken result with no new frame behind it leaves the register empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !frame.hit) |=> !out_valid_o)
    else $error("result repeated after being taken");

endmodule
